@@ src/eti_pkg.sv @@
// ----------------------------------------------------------------------------
// eti_pkg: shared types and constants of the orientation table interpolator
// Action and status codes, field widths, the table entry record.
// ----------------------------------------------------------------------------
package eti_pkg;

  localparam int unsigned DateW = 37;
  localparam int unsigned PoleW = 28;
  localparam int unsigned Ut1W  = 26;
  localparam int unsigned ThrW  = 25;

  typedef enum logic [1:0] {
    ActClear = 2'd0,
    ActLoad  = 2'd1,
    ActQuery = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StCoverage = 2'd1,
    StEmpty    = 2'd2,
    StFull     = 2'd3
  } status_e;

  localparam logic [0:0] RegLeapThreshold = 1'b0;
  localparam logic [ThrW-1:0] LeapThresholdReset = 25'd8388608;

  typedef struct packed {
    logic [DateW-1:0]        date;
    logic signed [PoleW-1:0] pole_x;
    logic signed [PoleW-1:0] pole_y;
    logic signed [Ut1W-1:0]  ut1;
  } entry_t;

endpackage

@@ src/eti_if.sv @@
// ----------------------------------------------------------------------------
// eti_in_if / eti_out_if: item channels of the table interpolator
// Valid/ready handshake carrying one request or one result.
// ----------------------------------------------------------------------------
interface eti_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [36:0]        mjd;
  logic signed [27:0] pole_x_in;
  logic signed [27:0] pole_y_in;
  logic signed [25:0] ut1_offset_in;
  modport source (output valid, action, mjd, pole_x_in, pole_y_in, ut1_offset_in,
                  input ready);
  modport sink (input valid, action, mjd, pole_x_in, pole_y_in, ut1_offset_in,
                output ready);
endinterface

interface eti_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [27:0] pole_x_out;
  logic signed [27:0] pole_y_out;
  logic signed [25:0] ut1_offset_out;
  logic               snapped;
  logic [10:0]        stored_entries;
  modport source (output valid, status, pole_x_out, pole_y_out, ut1_offset_out,
                  snapped, stored_entries, input ready);
  modport sink (input valid, status, pole_x_out, pole_y_out, ut1_offset_out,
                snapped, stored_entries, output ready);
endinterface

@@ src/eti_divider.sv @@
// ----------------------------------------------------------------------------
// eti_divider: restoring divider for the interpolation weight
// One quotient bit per cycle, FracW bits of floor(num * 2^FracW / den).
// ----------------------------------------------------------------------------
module eti_divider
  import eti_pkg::*;
#(
  parameter int unsigned FracW = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DateW-1:0] num_i,
  input  logic [DateW-1:0] den_i,
  output logic             done_o,
  output logic [FracW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(FracW + 1);

  logic [DateW:0]   rem_q, rem_d;
  logic [DateW-1:0] den_q;
  logic [FracW-1:0] quot_q, quot_d;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic [DateW+1:0] shifted;
  logic             ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {2'b00, den_q};

  always_comb begin
    rem_d  = ge ? (DateW + 1)'(shifted - {2'b00, den_q}) : shifted[DateW:0];
    quot_d = {quot_q[FracW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(FracW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, num_i};
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign quot_o = quot_q;

endmodule

@@ src/eti_lerp.sv @@
// ----------------------------------------------------------------------------
// eti_lerp: one linear interpolation lane
// lo + ((hi - lo) * w) >>> FracW, product registered before the add.
// ----------------------------------------------------------------------------
module eti_lerp
  import eti_pkg::*;
#(
  parameter int unsigned ValW  = 28,
  parameter int unsigned FracW = 24
) (
  input  logic                   clk_i,
  input  logic signed [ValW-1:0] lo_i,
  input  logic signed [ValW-1:0] hi_i,
  input  logic [FracW-1:0]       w_i,
  output logic signed [ValW-1:0] res_o
);

  localparam int unsigned ProdW = ValW + 1 + FracW + 1;

  logic signed [ValW:0]    diff;
  logic signed [ProdW-1:0] prod_q;

  assign diff = ValW'(hi_i) - ValW'(lo_i) + (ValW + 1)'(0);

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'($signed({{(ValW + 1){1'b0}}, 1'b0, w_i}) * ProdW'(diff));
  end

  assign res_o = ValW'(lo_i + ValW'(prod_q >>> FracW));

endmodule

@@ src/eop_table_interpolator_core.sv @@
// ----------------------------------------------------------------------------
// eop_table_interpolator_core: sorted orientation table with interpolation
// Holds dated pole x / pole y / UT1-UTC samples and answers date queries.
// ----------------------------------------------------------------------------
// Use: one request item per in channel handshake (clear, load, query), one
// result item per request on the out channel. leap_threshold sits at APB
// address 0; write it only while idle.
// Steps from accept to result valid, set by the table memory and sequencer:
//   clear, unused action, full-table load, empty-table query: output.
//   out-of-coverage query: first/last reads, one compare, output.
//   load: binary search steps, then a read and a write per shifted entry
//   (moved one slot up), up to TABLE_DEPTH-1 entries, then insert and output.
//   query: two bound reads, the search steps, two bracket reads, a capture
//   step; an exact date match then outputs. Otherwise divider start, the
//   divider run, a multiply-add step and the output step.
// One item is worked on at a time; the next is accepted the cycle after the
// result register has been taken.
// Reset clears the fill level and returns the threshold to 0.5 s; table
// contents are left unknown, only entries below the fill level are read.
// A stalled receiver holds the result register; no new item is accepted.
// ----------------------------------------------------------------------------
module eop_table_interpolator_core
  import eti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH      = 1024,
  parameter int unsigned WEIGHT_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  eti_in_if.sink      in_if,
  eti_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FracW = WEIGHT_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_RD_LAST, S_SRCH, S_SRCH_W, S_SHIFT_R, S_SHIFT_W,
    S_INSERT, S_RD_UP, S_RD_LO, S_LO_CAP, S_DIV_GO, S_DIV, S_MUL, S_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [ThrW-1:0] thr_q;
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'b00) ? {7'd0, thr_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thr_q <= LeapThresholdReset;
    else if (psel && penable && pwrite && paddr == 2'b00 && RegLeapThreshold == 1'b0)
      thr_q <= pwdata[ThrW-1:0];
  end

  // table memory, one read and one write port, registered read
  entry_t          mem [TABLE_DEPTH];
  logic [AddrW-1:0] raddr, waddr;
  logic             wen;
  entry_t           wdata, rdata_q;
  always_ff @(posedge clk_i) begin
    if (wen) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  // request and working registers
  logic [1:0]       act_q;
  entry_t           req_q;
  logic [CntW-1:0]  fill_q, lo_q, hi_q, pos_q;
  logic [CntW-1:0]  mid;
  entry_t           first_q, up_q, lo_e_q;
  logic             exact_q;
  logic [1:0]       st_q;
  logic             snap_q;
  logic signed [PoleW-1:0] px_q, py_q;
  logic signed [Ut1W-1:0]  ut_q;
  logic             ovalid_q;

  assign mid = lo_q + ((hi_q - lo_q) >> 1);

  // divider and lerp lanes
  logic             div_start, div_done;
  logic [FracW-1:0] w;
  eti_divider #(.FracW(FracW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .num_i(req_q.date - lo_e_q.date), .den_i(up_q.date - lo_e_q.date),
    .done_o(div_done), .quot_o(w)
  );
  logic signed [PoleW-1:0] lx, ly;
  logic signed [Ut1W-1:0]  lu;
  eti_lerp #(.ValW(PoleW), .FracW(FracW)) u_lx (
    .clk_i, .lo_i(lo_e_q.pole_x), .hi_i(up_q.pole_x), .w_i(w), .res_o(lx));
  eti_lerp #(.ValW(PoleW), .FracW(FracW)) u_ly (
    .clk_i, .lo_i(lo_e_q.pole_y), .hi_i(up_q.pole_y), .w_i(w), .res_o(ly));
  eti_lerp #(.ValW(Ut1W), .FracW(FracW)) u_lu (
    .clk_i, .lo_i(lo_e_q.ut1), .hi_i(up_q.ut1), .w_i(w), .res_o(lu));

  logic signed [Ut1W:0] dut;
  logic [Ut1W:0]        adut;
  assign dut  = (Ut1W + 1)'(up_q.ut1) - (Ut1W + 1)'(lo_e_q.ut1);
  assign adut = dut[Ut1W] ? (Ut1W + 1)'(-dut) : dut;

  logic go_right;
  assign go_right = (act_q == ActLoad) ? (rdata_q.date <= req_q.date)
                                       : (rdata_q.date <  req_q.date);

  assign in_if.ready = (state_q == S_IDLE) && !ovalid_q;
  // divider takes both bracket dates from registers
  assign div_start   = (state_q == S_DIV_GO);

  always_comb begin
    raddr = '0;
    unique case (state_q)
      S_RD_LAST: raddr = AddrW'(fill_q - 1'b1);
      S_SRCH:    raddr = mid[AddrW-1:0];
      S_SHIFT_R: raddr = pos_q[AddrW-1:0];
      S_RD_UP:   raddr = lo_q[AddrW-1:0];
      S_RD_LO:   raddr = AddrW'(lo_q - 1'b1);
      default:   raddr = '0;
    endcase
  end
  // shift moves entry pos up one slot; insert lands at the search result
  assign wen   = (state_q == S_SHIFT_W) || (state_q == S_INSERT);
  assign waddr = (state_q == S_SHIFT_W) ? AddrW'(pos_q + 1'b1) : lo_q[AddrW-1:0];
  assign wdata = (state_q == S_SHIFT_W) ? rdata_q : req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      ovalid_q <= 1'b0;
      act_q    <= ActNone;
      req_q    <= '0;
      st_q     <= StOk;
      snap_q   <= 1'b0;
      px_q     <= '0;
      py_q     <= '0;
      ut_q     <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      pos_q    <= '0;
      first_q  <= '0;
      up_q     <= '0;
      lo_e_q   <= '0;
      exact_q  <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (in_if.valid && in_if.ready) begin
          act_q  <= in_if.action;
          req_q  <= '{in_if.mjd, in_if.pole_x_in, in_if.pole_y_in, in_if.ut1_offset_in};
          st_q   <= StOk;
          snap_q <= 1'b0;
          px_q <= '0; py_q <= '0; ut_q <= '0;
          lo_q   <= '0;
          hi_q   <= fill_q;
          unique case (action_e'(in_if.action))
            ActClear: begin fill_q <= '0; state_q <= S_OUT; end
            ActLoad: begin
              if (fill_q == CntW'(TABLE_DEPTH)) begin
                st_q <= StFull; state_q <= S_OUT;
              end else state_q <= (fill_q == '0) ? S_INSERT : S_SRCH;
            end
            ActQuery: begin
              if (fill_q == '0) begin st_q <= StEmpty; state_q <= S_OUT; end
              else state_q <= S_RD_FIRST;
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_RD_FIRST: state_q <= S_RD_LAST;
        S_RD_LAST: begin first_q <= rdata_q; state_q <= S_SRCH; end
        S_SRCH: begin
          // first pass of a query: last entry is on the read port
          if (act_q == ActQuery && lo_q == '0 && hi_q == fill_q &&
              (req_q.date < first_q.date || req_q.date > rdata_q.date)) begin
            st_q <= StCoverage; state_q <= S_OUT;
          end else if (lo_q == hi_q) begin
            if (act_q == ActLoad) begin
              if (lo_q == fill_q) state_q <= S_INSERT;
              else begin
                pos_q   <= fill_q - 1'b1;
                state_q <= S_SHIFT_R;
              end
            end else state_q <= S_RD_UP;
          end else state_q <= S_SRCH_W;
        end
        S_SRCH_W: begin
          if (go_right) lo_q <= mid + 1'b1;
          else hi_q <= mid;
          state_q <= S_SRCH;
        end
        S_SHIFT_R: state_q <= S_SHIFT_W;
        S_SHIFT_W: begin
          if (pos_q == lo_q) state_q <= S_INSERT;
          else begin pos_q <= pos_q - 1'b1; state_q <= S_SHIFT_R; end
        end
        S_INSERT: begin
          fill_q  <= fill_q + 1'b1;
          state_q <= S_OUT;
        end
        S_RD_UP: state_q <= S_RD_LO;
        S_RD_LO: begin
          up_q <= rdata_q;
          exact_q <= (lo_q == '0) || (rdata_q.date == req_q.date);
          state_q <= S_LO_CAP;
        end
        S_LO_CAP: begin
          lo_e_q <= rdata_q;
          if (exact_q) begin
            px_q <= up_q.pole_x; py_q <= up_q.pole_y; ut_q <= up_q.ut1;
            state_q <= S_OUT;
          end else state_q <= S_DIV_GO;
        end
        S_DIV_GO: state_q <= S_DIV;
        S_DIV: if (div_done) state_q <= S_MUL;
        S_MUL: begin
          px_q <= lx; py_q <= ly;
          if (adut > (Ut1W + 1)'(thr_q)) begin
            snap_q <= 1'b1;
            ut_q   <= w[FracW-1] ? up_q.ut1 : lo_e_q.ut1;
          end else ut_q <= lu;
          state_q <= S_OUT;
        end
        S_OUT: begin ovalid_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid          = ovalid_q;
  assign out_if.status         = st_q;
  assign out_if.pole_x_out     = px_q;
  assign out_if.pole_y_out     = py_q;
  assign out_if.ut1_offset_out = ut_q;
  assign out_if.snapped        = snap_q;
  assign out_if.stored_entries = 11'(fill_q);

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CntW'(TABLE_DEPTH)) else $error("fill level over depth");
  a_snap_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.snapped |-> out_if.status == StOk)
    else $error("snap on failed item");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_if.ready) else $error("accept while busy");

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the orientation table interpolator
// Drives clear/load/query/unused-action items with random gaps, predicts each result from
// a local copy of the sorted table and compares field by field.
// ----------------------------------------------------------------------------
module testbench
  import eti_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth = 1024;
  localparam int unsigned Frac  = 24;

  typedef struct packed {
    logic [1:0]         action;
    logic [36:0]        mjd;
    logic signed [27:0] px;
    logic signed [27:0] py;
    logic signed [25:0] ut;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [27:0] px;
    logic signed [27:0] py;
    logic signed [25:0] ut;
    logic               snapped;
    logic [10:0]        stored;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  eti_in_if  req_ch ();
  eti_out_if ans_ch ();

  eop_table_interpolator_core i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (req_ch.sink),
    .out_if  (ans_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: mirror of the table, fill level and threshold.
  logic [36:0]        mdl_date [Depth];
  logic signed [27:0] mdl_px   [Depth];
  logic signed [27:0] mdl_py   [Depth];
  logic signed [25:0] mdl_ut   [Depth];
  int unsigned        mdl_fill;
  logic [24:0]        mdl_thr;

  req_t    pending_reqs[$];
  answer_t expected_answers[$];
  int unsigned errors = 0;
  int unsigned n_answers = 0, n_snap = 0, n_full = 0;

  function automatic void add_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // First index with date >= q, or > q when strict.
  function automatic int unsigned find_slot(logic [36:0] q, bit strict);
    int unsigned lo, hi, mid;
    bit right;
    lo = 0;
    hi = mdl_fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      right = strict ? (mdl_date[mid] <= q) : (mdl_date[mid] < q);
      if (right) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // lower + ((upper-lower)*w >>> Frac); >>> floors toward minus infinity.
  function automatic longint blend(longint a, longint b, longint w);
    longint p;
    p = (b - a) * w;
    return a + (p >>> Frac);
  endfunction

  function automatic answer_t predict_answer(req_t r);
    answer_t     a;
    int unsigned pos, up, lo;
    longint      d, rem, w, dut;
    a = '0;
    case (action_e'(r.action))
      ActClear: mdl_fill = 0;
      ActLoad: begin
        if (mdl_fill >= Depth) begin
          a.status = StFull;
        end else begin
          pos = find_slot(r.mjd, 1'b1);
          for (int i = int'(mdl_fill); i > int'(pos); i--) begin
            mdl_date[i] = mdl_date[i-1];
            mdl_px[i]   = mdl_px[i-1];
            mdl_py[i]   = mdl_py[i-1];
            mdl_ut[i]   = mdl_ut[i-1];
          end
          mdl_date[pos] = r.mjd;
          mdl_px[pos]   = r.px;
          mdl_py[pos]   = r.py;
          mdl_ut[pos]   = r.ut;
          mdl_fill++;
        end
      end
      ActQuery: begin
        if (mdl_fill == 0) begin
          a.status = StEmpty;
        end else if (r.mjd < mdl_date[0] || r.mjd > mdl_date[mdl_fill-1]) begin
          a.status = StCoverage;
        end else begin
          up = find_slot(r.mjd, 1'b0);
          if (up == 0 || mdl_date[up] == r.mjd) begin
            a.px = mdl_px[up];
            a.py = mdl_py[up];
            a.ut = mdl_ut[up];
          end else begin
            lo  = up - 1;
            d   = longint'(mdl_date[up]) - longint'(mdl_date[lo]);
            rem = longint'(r.mjd) - longint'(mdl_date[lo]);
            w   = 0;
            for (int i = 0; i < Frac; i++) begin
              rem = rem <<< 1;
              w   = w <<< 1;
              if (rem >= d) begin
                rem -= d;
                w |= 1;
              end
            end
            a.px = 28'(blend(longint'(mdl_px[lo]), longint'(mdl_px[up]), w));
            a.py = 28'(blend(longint'(mdl_py[lo]), longint'(mdl_py[up]), w));
            dut = longint'(mdl_ut[up]) - longint'(mdl_ut[lo]);
            if (dut < 0) dut = -dut;
            if (dut > longint'(mdl_thr)) begin
              a.snapped = 1'b1;
              a.ut = (w < (longint'(1) <<< (Frac - 1))) ? mdl_ut[lo] : mdl_ut[up];
            end else begin
              a.ut = 26'(blend(longint'(mdl_ut[lo]), longint'(mdl_ut[up]), w));
            end
          end
        end
      end
      default: ;
    endcase
    a.stored = 11'(mdl_fill);
    return a;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Request driver: changes at falling edges, holds valid until accepted.
  int unsigned drv_wait = 0;
  always @(negedge clk) begin
    if (rst_n && req_ch.valid && req_ch.ready) begin
      // accepted at the last rising edge; handled by the driver below
    end
  end

  bit req_taken;
  always @(posedge clk) req_taken <= rst_n && req_ch.valid && req_ch.ready;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.action = '0;
    req_ch.mjd = '0;
    req_ch.pole_x_in = '0;
    req_ch.pole_y_in = '0;
    req_ch.ut1_offset_in = '0;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && !req_taken) begin
        // still waiting for ready
      end else if (drv_wait != 0) begin
        req_ch.valid <= 1'b0;
        drv_wait <= drv_wait - 1;
      end else if (pending_reqs.size() != 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.action <= r.action;
        req_ch.mjd <= r.mjd;
        req_ch.pole_x_in <= r.px;
        req_ch.pole_y_in <= r.py;
        req_ch.ut1_offset_in <= r.ut;
        expected_answers.insert(expected_answers.size(), predict_answer(r));
        drv_wait <= gap_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: ready toggles with random stalls at falling edges.
  int unsigned stall = 0;
  initial ans_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall != 0) begin
        ans_ch.ready <= 1'b0;
        stall <= stall - 1;
      end else begin
        ans_ch.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall <= gap_len();
      end
    end
  end

  // Monitor: compare every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && ans_ch.valid && ans_ch.ready) begin
      answer_t got, exp_a;
      got = '{ans_ch.status, ans_ch.pole_x_out, ans_ch.pole_y_out,
              ans_ch.ut1_offset_out, ans_ch.snapped, ans_ch.stored_entries};
      if (expected_answers.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
      end else begin
        exp_a = expected_answers.pop_front();
        n_answers++;
        if (exp_a.snapped) n_snap++;
        if (exp_a.status == StFull) n_full++;
        if (got.status !== exp_a.status)
          $display("%0t: status exp %0d got %0d", $realtime, exp_a.status, got.status);
        if (got.px !== exp_a.px)
          $display("%0t: pole_x exp %0d got %0d", $realtime, exp_a.px, got.px);
        if (got.py !== exp_a.py)
          $display("%0t: pole_y exp %0d got %0d", $realtime, exp_a.py, got.py);
        if (got.ut !== exp_a.ut)
          $display("%0t: ut1 exp %0d got %0d", $realtime, exp_a.ut, got.ut);
        if (got.snapped !== exp_a.snapped)
          $display("%0t: snapped exp %0d got %0d", $realtime, exp_a.snapped, got.snapped);
        if (got.stored !== exp_a.stored)
          $display("%0t: stored exp %0d got %0d", $realtime, exp_a.stored, got.stored);
        if (got !== exp_a) errors++;
      end
    end
  end

  task automatic apb_write(logic [24:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'(RegLeapThreshold) * 2'd0;
    pwdata <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    mdl_thr = val;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_answers.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_t mk(action_e act, logic [36:0] mjd, logic [27:0] px,
                              logic [27:0] py, logic [25:0] ut);
    req_t r;
    r.action = act; r.mjd = mjd; r.px = px; r.py = py; r.ut = ut;
    return r;
  endfunction

  function automatic logic [36:0] rnd_date(logic [36:0] base, int unsigned span);
    return base + 37'($urandom_range(0, span));
  endfunction

  function automatic logic [36:0] rnd_full_date();
    logic [36:0] v;
    v = 37'({$urandom(), $urandom()});
    if (v > 37'd104857600000) v = v % 37'd104857600001;
    return v;
  endfunction

  // Random phase: small tables of random dates, queries inside and around, some clears and unused actions.
  task automatic random_phase(int unsigned n_items);
    logic [36:0] base, q;
    int unsigned span, k;
    base = rnd_full_date() % 37'd100000000000;
    span = $urandom_range(1, 3) == 1 ? 50 : 2000000;
    add_req(mk(ActClear, rnd_full_date(), 28'($urandom), 28'($urandom), 26'($urandom)));
    for (int i = 0; i < int'(n_items); i++) begin
      k = $urandom_range(0, 99);
      q = rnd_date(base, span);
      if (k < 25)
        add_req(mk(ActLoad, q, 28'($urandom), 28'($urandom),
            ($urandom_range(0, 3) == 0) ? 26'($urandom) : 26'($urandom_range(0, 9000000))));
      else if (k < 90)
        add_req(mk(ActQuery, q, 28'($urandom), 28'($urandom), 26'($urandom)));
      else if (k < 94)
        add_req(mk(ActQuery, rnd_full_date(), '0, '0, '0));
      else if (k < 96)
        add_req(mk(ActNone, rnd_full_date(), 28'($urandom), 28'($urandom), 26'($urandom)));
      else
        add_req(mk(ActClear, q, '0, '0, '0));
    end
  endtask

  initial begin
    mdl_fill = 0;
    mdl_thr = LeapThresholdReset;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty query, extremes, equal dates, leap snap, action 3.
    add_req(mk(ActQuery, 37'd5, '0, '0, '0));
    add_req(mk(ActLoad, 37'd1000, 28'h8000000, 28'h7ffffff, 26'h2000000));
    add_req(mk(ActLoad, 37'd1000, 28'h7ffffff, 28'h8000000, 26'h1ffffff));
    add_req(mk(ActLoad, 37'd3000, 28'h7ffffff, 28'h8000000, 26'h1ffffff));
    add_req(mk(ActLoad, 37'd104857600000, 28'h0, 28'h0, 26'h0));
    add_req(mk(ActLoad, 37'd0, 28'h1234567, 28'hfedcba9, 26'h0));
    add_req(mk(ActQuery, 37'd0, '0, '0, '0));
    add_req(mk(ActQuery, 37'd1000, '0, '0, '0));
    add_req(mk(ActQuery, 37'd1999, '0, '0, '0));
    add_req(mk(ActQuery, 37'd2001, '0, '0, '0));
    add_req(mk(ActQuery, 37'd3000, '0, '0, '0));
    add_req(mk(ActQuery, 37'd104857599999, '0, '0, '0));
    add_req(mk(ActQuery, 37'h1fffffffff, '0, '0, '0));
    add_req(mk(ActNone, 37'h1fffffffff, '1, '1, '1));
    add_req(mk(ActClear, '0, '0, '0, '0));
    add_req(mk(ActQuery, 37'd1000, '0, '0, '0));
    add_req(mk(ActLoad, 37'd10, 28'd100, 28'd100, 26'd0));
    add_req(mk(ActLoad, 37'd20, 28'd200, 28'd200, 26'd9000000));
    add_req(mk(ActQuery, 37'd0, '0, '0, '0));
    add_req(mk(ActQuery, 37'd14, '0, '0, '0));
    add_req(mk(ActQuery, 37'd15, '0, '0, '0));
    add_req(mk(ActQuery, 37'd21, '0, '0, '0));
    wait_idle();

    // Full table: fill to depth with ascending dates, then overflow and two queries.
    for (int i = 0; i < int'(Depth); i++)
      add_req(mk(ActLoad, 37'(i) * 37'd4096 + 37'd7, 28'($urandom), 28'($urandom),
                 26'($urandom_range(0, 4000000))));
    add_req(mk(ActLoad, 37'd50, '0, '0, '0));
    add_req(mk(ActQuery, 37'd100000, '0, '0, '0));
    add_req(mk(ActQuery, 37'd1023 * 37'd4096 + 37'd7, '0, '0, '0));
    wait_idle();

    apb_write(25'd0);
    random_phase(40);
    wait_idle();
    apb_write(25'h1ffffff);
    random_phase(40);
    wait_idle();
    apb_write(25'($urandom_range(0, 6000000)));
    random_phase(40);
    wait_idle();
    apb_write(LeapThresholdReset);
    random_phase(40);
    wait_idle();

    $display("Covered %0d results: %0d snapped, %0d full-table drops, four thresholds.",
             n_answers, n_snap, n_full);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
